FILE: hw/rtl/sstg_pkg.sv
// ============================================================================
// Sine tone generator package
// Shared widths, fixed-point constants and request types for the tone
// generator and its iterative divider and sine units.
// ============================================================================
package sstg_pkg;

    // Angle resolution and derived widths of the sine evaluation
    localparam int PHASE_BITS = 12;
    localparam int QBITS      = PHASE_BITS - 2;
    localparam int R_W        = QBITS + 1;
    localparam int RSQ_W      = 2 * QBITS + 1;
    localparam int P_W        = 32;
    localparam int PROD_W     = P_W + RSQ_W + 1;
    localparam int SINE_W     = 16;

    // Rounding offsets that make arithmetic shifts truncate toward zero
    localparam longint H_BIAS = (longint'(1) << (2 * QBITS)) - 1;
    localparam longint F_BIAS = (longint'(1) << QBITS) - 1;

    // Odd polynomial coefficients of the quarter wave in Q30
    localparam logic signed [P_W-1:0] C1 = 32'sd1686629713;
    localparam logic signed [P_W-1:0] C3 = 32'sd693598672;
    localparam logic signed [P_W-1:0] C5 = 32'sd85569278;
    localparam logic signed [P_W-1:0] C7 = 32'sd5026937;

    // Channel limit
    localparam int MAX_CHANNELS = 8;

    // Shared divider
    localparam int DIV_W     = 18;
    localparam int DIV_CNT_W = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_TONE_FREQUENCY  = 3'd0;
    localparam logic [2:0] CFG_OUTPUT_RATE     = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_TOTAL   = 3'd2;
    localparam logic [2:0] CFG_WIDE_SAMPLES    = 3'd3;
    localparam logic [2:0] CFG_SIGNED_SAMPLES  = 3'd4;
    localparam logic [2:0] CFG_BIG_ENDIAN      = 3'd5;
    localparam logic [2:0] CFG_TONE_ON_RIGHT   = 3'd6;
    localparam logic [2:0] CFG_FRAMES_PER_LOOP = 3'd7;

    // Divide request: the remainder starts at rem_init (below divisor) and
    // steps dividend bits are shifted in from the top.
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: hw/rtl/sstg_div.sv
// ============================================================================
// Shared restoring divider
// Produces one quotient bit per cycle; used for the phase reduction, the
// frequency step reduction and the phase-to-angle conversion.
// ============================================================================
module sstg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sstg_pkg::t_div_req i_req,
    output sstg_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [sstg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [sstg_pkg::DIV_W-1:0]     r_rem;
    logic [sstg_pkg::DIV_W-1:0]     r_dvd;
    logic [sstg_pkg::DIV_W-1:0]     r_quot;
    logic [sstg_pkg::DIV_W-1:0]     r_div;

    logic [sstg_pkg::DIV_W:0]       trial;
    logic [sstg_pkg::DIV_W:0]       diff;
    logic                           fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {r_rem, r_dvd[sstg_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem_init;
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[sstg_pkg::DIV_W-1:0] : trial[sstg_pkg::DIV_W-1:0];
                r_dvd  <= {r_dvd[sstg_pkg::DIV_W-2:0], 1'b0};
                r_quot <= {r_quot[sstg_pkg::DIV_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == sstg_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: hw/rtl/sstg_sine.sv
// ============================================================================
// Sine evaluation unit
// Evaluates the quarter-wave polynomial in Horner form with one shared
// multiplier, then rounds to Q1.15 and applies the quadrant sign.
// ============================================================================
module sstg_sine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sstg_pkg::PHASE_BITS-1:0]     i_angle,
    output logic                                o_done,
    output logic signed [sstg_pkg::SINE_W-1:0]  o_sine
);

    typedef enum logic [2:0] {
        SN_IDLE,
        SN_SQ_MUL,
        SN_SQ_SAVE,
        SN_H_MUL,
        SN_H_ADD,
        SN_F_MUL,
        SN_F_ADD
    } t_sn_state;

    t_sn_state                            r_state;
    logic [1:0]                           r_k;
    logic                                 r_neg;
    logic [sstg_pkg::R_W-1:0]             r_r;
    logic signed [sstg_pkg::P_W-1:0]      r_a;
    logic [sstg_pkg::RSQ_W-1:0]           r_b;
    logic signed [sstg_pkg::PROD_W-1:0]   r_prod;
    logic                                 r_done;
    logic signed [sstg_pkg::SINE_W-1:0]   r_sine;

    logic [1:0]                           quad;
    logic [sstg_pkg::QBITS-1:0]           roff;
    logic [sstg_pkg::R_W-1:0]             r_in;
    logic signed [sstg_pkg::PROD_W-1:0]   mul_res;
    logic signed [sstg_pkg::PROD_W-1:0]   h_sh;
    logic signed [sstg_pkg::PROD_W-1:0]   f_sh;
    logic signed [sstg_pkg::P_W:0]        f_t;
    logic [sstg_pkg::P_W-15:0]            f_rnd;
    logic [sstg_pkg::SINE_W-2:0]          mag;

    // Horner coefficient for each of the three accumulate steps
    function automatic logic signed [sstg_pkg::P_W-1:0] horner_coef(input logic [1:0] k);
        logic signed [sstg_pkg::P_W-1:0] c;
        unique case (k)
            2'd0:    c = sstg_pkg::C5;
            2'd1:    c = -sstg_pkg::C3;
            default: c = sstg_pkg::C1;
        endcase
        return c;
    endfunction

    // Quadrant split; the offset is mirrored in odd quadrants.
    assign quad = i_angle[sstg_pkg::PHASE_BITS-1 -: 2];
    assign roff = i_angle[sstg_pkg::QBITS-1:0];
    assign r_in = quad[0] ? ((sstg_pkg::R_W'(1) << sstg_pkg::QBITS) - sstg_pkg::R_W'(roff))
                          : sstg_pkg::R_W'(roff);

    // The shared multiplier
    assign mul_res = sstg_pkg::PROD_W'(r_a) *
                     sstg_pkg::PROD_W'($signed({1'b0, r_b}));

    // Truncating scale-downs after the multiply
    assign h_sh = r_prod[sstg_pkg::PROD_W-1]
                ? (r_prod + sstg_pkg::PROD_W'(sstg_pkg::H_BIAS)) >>> (2 * sstg_pkg::QBITS)
                : r_prod >>> (2 * sstg_pkg::QBITS);
    assign f_sh = r_prod[sstg_pkg::PROD_W-1]
                ? (r_prod + sstg_pkg::PROD_W'(sstg_pkg::F_BIAS)) >>> sstg_pkg::QBITS
                : r_prod >>> sstg_pkg::QBITS;

    // Round to Q15 and saturate; negative results clamp to zero.
    assign f_t   = (sstg_pkg::P_W+1)'(f_sh[sstg_pkg::P_W-1:0]) + (sstg_pkg::P_W+1)'(16384);
    assign f_rnd = f_t[sstg_pkg::P_W:15];
    assign mag   = f_t[sstg_pkg::P_W] ? '0
                 : ((f_rnd > (sstg_pkg::P_W-14)'(32767)) ? '1 : f_rnd[sstg_pkg::SINE_W-2:0]);

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SN_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                SN_IDLE: begin
                    if (i_start) begin
                        r_neg   <= quad[1];
                        r_r     <= r_in;
                        r_a     <= sstg_pkg::P_W'($signed({1'b0, r_in}));
                        r_b     <= sstg_pkg::RSQ_W'(r_in);
                        r_state <= SN_SQ_MUL;
                    end
                end
                SN_SQ_MUL: begin
                    r_prod  <= mul_res;
                    r_state <= SN_SQ_SAVE;
                end
                SN_SQ_SAVE: begin
                    r_b     <= r_prod[sstg_pkg::RSQ_W-1:0];
                    r_a     <= -sstg_pkg::C7;
                    r_k     <= '0;
                    r_state <= SN_H_MUL;
                end
                SN_H_MUL: begin
                    r_prod  <= mul_res;
                    r_state <= SN_H_ADD;
                end
                SN_H_ADD: begin
                    r_a <= horner_coef(r_k) + h_sh[sstg_pkg::P_W-1:0];
                    if (r_k == 2'd2) begin
                        r_b     <= sstg_pkg::RSQ_W'(r_r);
                        r_state <= SN_F_MUL;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= SN_H_MUL;
                    end
                end
                SN_F_MUL: begin
                    r_prod  <= mul_res;
                    r_state <= SN_F_ADD;
                end
                SN_F_ADD: begin
                    r_sine  <= r_neg ? -sstg_pkg::SINE_W'(mag) : sstg_pkg::SINE_W'(mag);
                    r_done  <= 1'b1;
                    r_state <= SN_IDLE;
                end
                default: r_state <= SN_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sine = r_sine;

endmodule

FILE: hw/rtl/single_channel_sine_tone_generator.sv
// ============================================================================
// Single channel sine tone generator
// Each frame_tick request produces one interleaved frame: the tone sample on
// the tone channel and silence on the others, the final sample flagged with tlast.
// ============================================================================
// Flow: the shared bit-serial divider reduces the phase and the frequency
//   when needed and converts the phase to an angle, then the sine unit runs;
//   one sample leaves per cycle while the sample stream is ready. A new request
//   is taken only once the previous frame's last sample is in the output register.
// Reset: configuration returns to 1 kHz at 48000 frames/s, two 16-bit signed
//   channels, and the phase and frame position clear to zero.
module single_channel_sine_tone_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] frame_tick
    // Sample stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] channel_index
    output logic        o_m_axis_tlast,   // last_of_frame
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODP_W,
        ST_STEP,
        ST_STEP_W,
        ST_ANG,
        ST_ANG_W,
        ST_SINE_W,
        ST_ENC_Y,
        ST_ENC_Q,
        ST_EMIT,
        ST_UPDATE
    } t_state;

    // Configuration registers
    logic [17:0] r_tone_frequency;
    logic [17:0] r_output_rate;
    logic [3:0]  r_channel_total;
    logic        r_wide_samples;
    logic        r_signed_samples;
    logic        r_big_endian;
    logic        r_tone_on_right;
    logic [23:0] r_frames_per_loop;

    // Tone state and sequencer registers
    t_state                              r_state;
    logic [17:0]                         r_phase;
    logic [23:0]                         r_pos;
    logic [17:0]                         r_step;
    logic signed [sstg_pkg::SINE_W-1:0]  r_sine;
    logic [17:0]                         r_enc_y;
    logic                                r_enc_neg;
    logic [15:0]                         r_tone_code;
    logic [2:0]                          r_chan;
    sstg_pkg::t_div_req                  r_div_req;
    logic                                r_sine_start;
    logic [sstg_pkg::PHASE_BITS-1:0]     r_sine_angle;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic [2:0]  r_out_chan;
    logic        r_out_last;

    sstg_pkg::t_div_rsp                  div_rsp;
    logic                                sine_done;
    logic signed [sstg_pkg::SINE_W-1:0]  sine_val;

    logic        s_acc;
    logic        out_free;
    logic [2:0]  chans_m1;
    logic        has_tone;
    logic        rate_zero;
    logic [15:0] abs_s;
    logic [18:0] off_s;
    logic [18:0] enc_val;
    logic [15:0] enc_k;
    logic [34:0] enc_prod;
    logic [33:0] q_prod;
    logic [15:0] q_val;
    logic [15:0] code_raw;
    logic [15:0] silence;
    logic [15:0] chan_word;
    logic [15:0] chan_word_ord;
    logic [18:0] phase_sum;
    logic [17:0] phase_adv;
    logic [23:0] pos_inc;

    // Build a divide request
    function automatic sstg_pkg::t_div_req make_div(
        input logic [sstg_pkg::DIV_W-1:0]     rem_init,
        input logic [sstg_pkg::DIV_W-1:0]     dividend,
        input logic [sstg_pkg::DIV_CNT_W-1:0] steps,
        input logic [sstg_pkg::DIV_W-1:0]     divisor
    );
        sstg_pkg::t_div_req req;
        req.start    = 1'b1;
        req.rem_init = rem_init;
        req.dividend = dividend;
        req.steps    = steps;
        req.divisor  = divisor;
        return req;
    endfunction

    // Midpoint code of each sample format
    function automatic logic [15:0] silence_code(input logic wide, input logic sgn);
        logic [15:0] c;
        if (sgn) begin
            c = 16'd0;
        end else begin
            c = wide ? 16'd32767 : 16'd127;
        end
        return c;
    endfunction

    // Shared units
    sstg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    sstg_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sine_start),
        .i_angle (r_sine_angle),
        .o_done  (sine_done),
        .o_sine  (sine_val)
    );

    // Handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Channel count clamped to one through MAX_CHANNELS
    always_comb begin
        if (r_channel_total == 4'd0) begin
            chans_m1 = 3'd0;
        end else if (r_channel_total > 4'(sstg_pkg::MAX_CHANNELS)) begin
            chans_m1 = 3'(sstg_pkg::MAX_CHANNELS - 1);
        end else begin
            chans_m1 = 3'(r_channel_total - 4'd1);
        end
    end

    assign has_tone  = r_tone_on_right ? (chans_m1 != 3'd0) : 1'b1;
    assign rate_zero = (r_output_rate == 18'd0);

    // Sample encoding, first stage: scale by the full-scale code and the
    // power-of-two part of the 0.1 amplitude divisor.
    assign abs_s   = r_sine[sstg_pkg::SINE_W-1] ? 16'(-r_sine) : 16'(r_sine);
    assign off_s   = 19'd327680 + 19'(r_sine);
    assign enc_val = r_signed_samples ? {4'b0, abs_s[14:0]} : off_s;
    assign enc_k   = r_signed_samples ? (r_wide_samples ? 16'd32767 : 16'd127)
                                      : (r_wide_samples ? 16'd65535 : 16'd255);
    assign enc_prod = 35'(enc_val) * 35'(enc_k);

    // Second stage: divide by five through the reciprocal, exact below 2^18.
    assign q_prod   = 34'(r_enc_y) * 34'(16'd52429);
    assign q_val    = q_prod[33:18];
    assign code_raw = (r_signed_samples && r_enc_neg) ? 16'(-q_val) : q_val;

    // Per-channel word with byte order applied
    assign silence       = silence_code(r_wide_samples, r_signed_samples);
    assign chan_word     = (has_tone && (r_chan == {2'b00, r_tone_on_right}))
                         ? r_tone_code : silence;
    assign chan_word_ord = (r_wide_samples && r_big_endian)
                         ? {chan_word[7:0], chan_word[15:8]} : chan_word;

    // Phase advance and loop position
    assign phase_sum = {1'b0, r_phase} + {1'b0, r_step};
    assign phase_adv = (phase_sum >= {1'b0, r_output_rate})
                     ? 18'(phase_sum - {1'b0, r_output_rate}) : phase_sum[17:0];
    assign pos_inc   = r_pos + 24'd1;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_frequency  <= 18'd1000;
            r_output_rate     <= 18'd48000;
            r_channel_total   <= 4'd2;
            r_wide_samples    <= 1'b1;
            r_signed_samples  <= 1'b1;
            r_big_endian      <= 1'b0;
            r_tone_on_right   <= 1'b0;
            r_frames_per_loop <= 24'd48000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sstg_pkg::CFG_TONE_FREQUENCY:  r_tone_frequency  <= i_cfg_data[17:0];
                sstg_pkg::CFG_OUTPUT_RATE:     r_output_rate     <= i_cfg_data[17:0];
                sstg_pkg::CFG_CHANNEL_TOTAL:   r_channel_total   <= i_cfg_data[3:0];
                sstg_pkg::CFG_WIDE_SAMPLES:    r_wide_samples    <= i_cfg_data[0];
                sstg_pkg::CFG_SIGNED_SAMPLES:  r_signed_samples  <= i_cfg_data[0];
                sstg_pkg::CFG_BIG_ENDIAN:      r_big_endian      <= i_cfg_data[0];
                sstg_pkg::CFG_TONE_ON_RIGHT:   r_tone_on_right   <= i_cfg_data[0];
                sstg_pkg::CFG_FRAMES_PER_LOOP: r_frames_per_loop <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame sequencer, tone state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_phase         <= '0;
            r_pos           <= '0;
            r_chan          <= '0;
            r_div_req.start <= 1'b0;
            r_sine_start    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            r_sine_start    <= 1'b0;
            if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                // Wait for a request; reduce the stored phase if needed.
                ST_IDLE: begin
                    if (s_acc && i_s_axis_tdata[0]) begin
                        r_chan <= '0;
                        if (rate_zero) begin
                            r_phase <= '0;
                            r_sine  <= '0;
                            r_state <= ST_ENC_Y;
                        end else if (r_phase >= r_output_rate) begin
                            r_div_req <= make_div('0, r_phase,
                                sstg_pkg::DIV_CNT_W'(sstg_pkg::DIV_W), r_output_rate);
                            r_state   <= ST_MODP_W;
                        end else begin
                            r_state <= ST_STEP;
                        end
                    end
                end
                ST_MODP_W: begin
                    if (div_rsp.done) begin
                        r_phase <= div_rsp.rem;
                        r_state <= ST_STEP;
                    end
                end
                // Per-frame phase step is the frequency modulo the rate.
                ST_STEP: begin
                    if (r_tone_frequency < r_output_rate) begin
                        r_step  <= r_tone_frequency;
                        r_state <= ST_ANG;
                    end else begin
                        r_div_req <= make_div('0, r_tone_frequency,
                            sstg_pkg::DIV_CNT_W'(sstg_pkg::DIV_W), r_output_rate);
                        r_state   <= ST_STEP_W;
                    end
                end
                ST_STEP_W: begin
                    if (div_rsp.done) begin
                        r_step  <= div_rsp.rem;
                        r_state <= ST_ANG;
                    end
                end
                // Angle index is (phase << PHASE_BITS) / rate.
                ST_ANG: begin
                    if (has_tone) begin
                        r_div_req <= make_div(r_phase, '0,
                            sstg_pkg::DIV_CNT_W'(sstg_pkg::PHASE_BITS), r_output_rate);
                        r_state   <= ST_ANG_W;
                    end else begin
                        r_sine  <= '0;
                        r_state <= ST_ENC_Y;
                    end
                end
                ST_ANG_W: begin
                    if (div_rsp.done) begin
                        r_sine_angle <= div_rsp.quot[sstg_pkg::PHASE_BITS-1:0];
                        r_sine_start <= 1'b1;
                        r_state      <= ST_SINE_W;
                    end
                end
                ST_SINE_W: begin
                    if (sine_done) begin
                        r_sine  <= sine_val;
                        r_state <= ST_ENC_Y;
                    end
                end
                // Two-stage sample encoding of the tone value
                ST_ENC_Y: begin
                    r_enc_y   <= r_signed_samples ? enc_prod[33:16] : enc_prod[34:17];
                    r_enc_neg <= r_sine[sstg_pkg::SINE_W-1];
                    r_state   <= ST_ENC_Q;
                end
                ST_ENC_Q: begin
                    r_tone_code <= r_wide_samples ? code_raw : {8'h00, code_raw[7:0]};
                    r_state     <= ST_EMIT;
                end
                // One sample per channel into the output register
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= chan_word_ord;
                        r_out_chan  <= r_chan;
                        r_out_last  <= (r_chan == chans_m1);
                        if (r_chan == chans_m1) begin
                            r_state <= ST_UPDATE;
                        end else begin
                            r_chan <= r_chan + 3'd1;
                        end
                    end
                end
                // Advance the phase and the loop position, clearing both at the loop end.
                ST_UPDATE: begin
                    if (pos_inc >= r_frames_per_loop) begin
                        r_pos   <= '0;
                        r_phase <= '0;
                    end else begin
                        r_pos <= pos_inc;
                        if (has_tone && !rate_zero) begin
                            r_phase <= phase_adv;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = r_out_chan;
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: dv/tb_top.sv
// ============================================================================
// Sine tone generator testbench
// Sends frame requests through the request stream and checks every sample of
// the sample stream against a predictor of the tone generator that runs on
// its own copy of the configuration, phase and frame position. A directed
// part covers the channel, format and rate corner cases, then random setups
// follow, each written while the block is idle, with random gaps and stalls
// on both streams.
// ============================================================================
module tb_top;
    import sstg_pkg::*;

    // Timing of the run
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 3000;
    localparam int FRAME_TARGET  = 280;

    // Fixed-point constants of the quarter-wave polynomial in Q30
    localparam int     QTR_BITS = PHASE_BITS - 2;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint K1       = 64'sd1686629713;
    localparam longint K3       = 64'sd693598672;
    localparam longint K5       = 64'sd85569278;
    localparam longint K7       = 64'sd5026937;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_WRITE,
        OP_SETTLE
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic [7:0]  tdata;
        int          gap;
        logic [2:0]  addr;
        logic [23:0] wdata;
    } t_stim_op;

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] word;
        logic        last;
    } t_sample;

    // DUT connections
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [7:0]  req_data  = 8'h00;
    logic        smp_valid;
    logic        smp_ready = 1'b0;
    logic [15:0] smp_data;
    logic [2:0]  smp_user;
    logic        smp_last;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = CFG_TONE_FREQUENCY;
    logic [23:0] cfg_data  = 24'h000000;

    // Predictor copy of the configuration and state, at reset values
    logic [17:0] tone_freq    = 18'd1000;
    logic [17:0] frame_rate   = 18'd48000;
    logic [3:0]  chan_setting = 4'd2;
    logic        wide_words   = 1'b1;
    logic        twos_comp    = 1'b1;
    logic        swap_bytes   = 1'b0;
    logic        right_tone   = 1'b0;
    logic [23:0] loop_frames  = 24'd48000;
    int unsigned phase_acc    = 0;
    logic [23:0] frame_pos    = 24'd0;

    t_stim_op stim_q[$];
    t_sample  expected_samples[$];

    bit steady_source = 1'b1;
    bit steady_sink   = 1'b1;
    int frames_queued = 0;
    int idle_queued   = 0;
    int setups        = 0;
    int frames_sent   = 0;
    int writes_done   = 0;
    int samples_seen  = 0;
    int fail_count    = 0;
    int settle_cnt    = 0;
    int stall_cnt     = 0;
    int idle_cycles   = 0;

    single_channel_sine_tone_generator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (smp_valid),
        .i_m_axis_tready (smp_ready),
        .o_m_axis_tdata  (smp_data),
        .o_m_axis_tuser  (smp_user),
        .o_m_axis_tlast  (smp_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Sine of angle/2^PHASE_BITS turns in Q1.15, from the odd quarter-wave
    // polynomial with truncating Q30 products.
    function automatic int sine_q15(input logic [PHASE_BITS-1:0] angle);
        int unsigned quad;
        int unsigned offset;
        longint      u;
        longint      u2;
        longint      p;
        longint      s;
        quad   = angle[PHASE_BITS-1 -: 2];
        offset = angle[QTR_BITS-1:0];
        if ((quad & 1) != 0) offset = (1 << QTR_BITS) - offset;
        u  = longint'(offset) << (30 - QTR_BITS);
        u2 = (u * u) / ONE_Q30;
        p  = -K7;
        p  = K5 + (p * u2) / ONE_Q30;
        p  = -K3 + (p * u2) / ONE_Q30;
        p  = K1 + (p * u2) / ONE_Q30;
        s  = (p * u) / ONE_Q30;
        s  = (s + 16384) / 32768;
        if (s > 32767) s = 32767;
        if (s < 0) s = 0;
        return ((quad & 2) != 0) ? -int'(s) : int'(s);
    endfunction

    // Scale a Q1.15 level by 0.1 into the configured sample code.
    function automatic logic [15:0] encode_sample(input int level);
        longint      v;
        logic [63:0] t;
        v = level;
        if (twos_comp) t = wide_words ? (v * 32767) / 327680 : (v * 127) / 327680;
        else t = wide_words ? ((327680 + v) * 65535) / 655360
                            : ((327680 + v) * 255) / 655360;
        return wide_words ? t[15:0] : {8'h00, t[7:0]};
    endfunction

    function automatic void apply_register(input logic [2:0] addr, input logic [23:0] data);
        case (addr)
            CFG_TONE_FREQUENCY:  tone_freq    = data[17:0];
            CFG_OUTPUT_RATE:     frame_rate   = data[17:0];
            CFG_CHANNEL_TOTAL:   chan_setting = data[3:0];
            CFG_WIDE_SAMPLES:    wide_words   = data[0];
            CFG_SIGNED_SAMPLES:  twos_comp    = data[0];
            CFG_BIG_ENDIAN:      swap_bytes   = data[0];
            CFG_TONE_ON_RIGHT:   right_tone   = data[0];
            CFG_FRAMES_PER_LOOP: loop_frames  = data[23:0];
            default: ;
        endcase
    endfunction

    // Work out the samples of one frame request and advance the phase.
    function automatic void predict_frame(input logic [7:0] req);
        int unsigned n_ch;
        int unsigned tone_ch;
        bit          has_tone;
        int          tone_level;
        logic [63:0] angle;
        t_sample     smp;
        if (req[0] == 1'b0) return;
        n_ch = (chan_setting == 0) ? 1 :
               (chan_setting > MAX_CHANNELS) ? MAX_CHANNELS : chan_setting;
        tone_ch    = right_tone ? 1 : 0;
        has_tone   = tone_ch < n_ch;
        tone_level = 0;
        if (frame_rate == 0) phase_acc = 0;
        else phase_acc = phase_acc % frame_rate;
        if (has_tone && frame_rate != 0) begin
            angle      = (longint'(phase_acc) << PHASE_BITS) / frame_rate;
            tone_level = sine_q15(angle[PHASE_BITS-1:0]);
        end
        for (int i = 0; i < n_ch; i++) begin
            smp.chan = i;
            smp.word = encode_sample((has_tone && i == tone_ch) ? tone_level : 0);
            if (wide_words && swap_bytes) smp.word = {smp.word[7:0], smp.word[15:8]};
            smp.last = (i + 1 == n_ch);
            expected_samples.push_back(smp);
        end
        if (has_tone && frame_rate != 0) begin
            phase_acc = phase_acc + (tone_freq % frame_rate);
            if (phase_acc >= frame_rate) phase_acc = phase_acc - frame_rate;
        end
        frame_pos = frame_pos + 24'd1;
        if (frame_pos >= loop_frames) begin
            frame_pos = 24'd0;
            phase_acc = 0;
        end
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", what);
    endfunction

    // Stimulus queue helpers
    function automatic void queue_request(input bit tick);
        t_stim_op op;
        op.kind  = OP_REQUEST;
        op.tdata = {7'd0, tick};
        op.gap   = steady_source ? 0 : $urandom_range(0, 16);
        op.addr  = CFG_TONE_FREQUENCY;
        op.wdata = 24'd0;
        stim_q.push_back(op);
        if (tick) frames_queued++;
        else idle_queued++;
    endfunction

    function automatic void queue_write(input logic [2:0] addr, input logic [23:0] data);
        t_stim_op op;
        op.kind  = OP_WRITE;
        op.tdata = 8'h00;
        op.gap   = 0;
        op.addr  = addr;
        op.wdata = data;
        stim_q.push_back(op);
    endfunction

    function automatic void queue_pause();
        t_stim_op op;
        op.kind  = OP_SETTLE;
        op.tdata = 8'h00;
        op.gap   = 0;
        op.addr  = CFG_TONE_FREQUENCY;
        op.wdata = 24'd0;
        stim_q.push_back(op);
    endfunction

    // Random setup: each register written with some chance, values biased
    // toward small rates, rates far below the frequency and short loops.
    function automatic void queue_random_setup(input bit write_all);
        logic [17:0] rate;
        logic [17:0] freq;
        logic [23:0] loop_len;
        logic [23:0] noise;
        case ($urandom_range(0, 4))
            0:       rate = $urandom_range(1, 16);
            1:       rate = 8000 * $urandom_range(1, 24);
            2:       rate = ($urandom_range(0, 1) != 0) ? 18'h3FFFF : 18'd0;
            default: rate = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       freq = $urandom_range(0, 16);
            1:       freq = (rate == 0) ? 18'd0 : $urandom % rate;
            2:       freq = $urandom;
            3:       freq = 18'd0;
            default: freq = $urandom_range(20, 20000);
        endcase
        case ($urandom_range(0, 5))
            0:       loop_len = 24'd0;
            1:       loop_len = 24'd1;
            2:       loop_len = 24'hFFFFFF;
            3:       loop_len = $urandom;
            default: loop_len = $urandom_range(2, 50);
        endcase
        // Now and then the unused upper data bits carry noise.
        noise = ($urandom_range(0, 7) == 0) ? $urandom : 24'd0;
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_TONE_FREQUENCY, {noise[23:18], freq});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_OUTPUT_RATE, {noise[23:18], rate});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_CHANNEL_TOTAL, {noise[23:4], 4'($urandom_range(0, 15))});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_WIDE_SAMPLES, {noise[23:1], 1'($urandom_range(0, 1))});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_SIGNED_SAMPLES, {noise[23:1], 1'($urandom_range(0, 1))});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_BIG_ENDIAN, {noise[23:1], 1'($urandom_range(0, 1))});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_TONE_ON_RIGHT, {noise[23:1], 1'($urandom_range(0, 1))});
        if (write_all || $urandom_range(0, 1))
            queue_write(CFG_FRAMES_PER_LOOP, loop_len);
    endfunction

    // Request driver: presents queued requests and register writes, and
    // predicts each frame when its request is accepted.
    always @(posedge clk) begin : request_driver
        t_stim_op    op;
        logic        nxt_valid;
        logic [7:0]  nxt_data;
        logic        nxt_we;
        logic [2:0]  nxt_addr;
        logic [23:0] nxt_wdata;
        nxt_valid = req_valid;
        nxt_data  = req_data;
        nxt_we    = 1'b0;
        nxt_addr  = cfg_addr;
        nxt_wdata = cfg_data;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (cfg_we) begin
                apply_register(cfg_addr, cfg_data);
                writes_done++;
            end
            if (req_valid && req_ready) begin
                predict_frame(req_data);
                frames_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && stim_q.size() != 0) begin
                op = stim_q[0];
                case (op.kind)
                    OP_REQUEST: begin
                        if (op.gap != 0) begin
                            stim_q[0].gap = op.gap - 1;
                        end else begin
                            nxt_valid = 1'b1;
                            nxt_data  = op.tdata;
                            void'(stim_q.pop_front());
                        end
                    end
                    OP_WRITE: begin
                        nxt_we    = 1'b1;
                        nxt_addr  = op.addr;
                        nxt_wdata = op.wdata;
                        void'(stim_q.pop_front());
                    end
                    default: begin
                        // Hold off until all samples are back and the block
                        // has had time to finish any frame still in flight.
                        if (expected_samples.size() != 0) begin
                            settle_cnt = 0;
                        end else if (settle_cnt >= SETTLE_CYCLES) begin
                            settle_cnt = 0;
                            void'(stim_q.pop_front());
                        end else begin
                            settle_cnt++;
                        end
                    end
                endcase
            end
        end
        req_valid <= nxt_valid;
        req_data  <= nxt_data;
        cfg_we    <= nxt_we;
        cfg_addr  <= nxt_addr;
        cfg_data  <= nxt_wdata;
    end

    // Sample monitor: checks each accepted sample and draws a stall after it.
    always @(posedge clk) begin : sample_monitor
        t_sample got;
        t_sample want;
        int      hold;
        logic    nxt_ready;
        nxt_ready = smp_ready;
        if (!rst_n) begin
            nxt_ready = 1'b0;
        end else if (smp_valid && smp_ready) begin
            got.chan = smp_user;
            got.word = smp_data;
            got.last = smp_last;
            samples_seen++;
            if (expected_samples.size() == 0) begin
                note_failure($sformatf("unexpected sample ch %0d word %04h last %0b",
                                       got.chan, got.word, got.last));
            end else begin
                want = expected_samples.pop_front();
                if (got.chan !== want.chan || got.word !== want.word ||
                    got.last !== want.last)
                    note_failure($sformatf(
                        "sample %0d expected ch %0d word %04h last %0b, got ch %0d word %04h last %0b",
                        samples_seen, want.chan, want.word, want.last,
                        got.chan, got.word, got.last));
            end
            if (samples_seen % 48 == 0) steady_sink = ($urandom_range(0, 2) == 0);
            hold = steady_sink ? 0 : $urandom_range(0, 16);
            if (hold == 0) begin
                nxt_ready = 1'b1;
            end else begin
                nxt_ready = 1'b0;
                stall_cnt = hold;
            end
        end else if (!smp_ready) begin
            if (stall_cnt <= 1) nxt_ready = 1'b1;
            if (stall_cnt > 0) stall_cnt--;
        end
        smp_ready <= nxt_ready;
    end

    // Watchdog on cycles without any handshake or register write.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (req_valid && req_ready) || (smp_valid && smp_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d samples outstanding",
                     STALL_LIMIT, expected_samples.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed part, reset configuration first, including an empty tick.
        steady_source = 1'b1;
        queue_request(1'b1);
        queue_request(1'b0);
        queue_request(1'b1);
        queue_request(1'b1);

        // Eight channels of offset-unsigned bytes with the tone on the right.
        queue_pause();
        queue_write(CFG_CHANNEL_TOTAL, 24'd8);
        queue_write(CFG_TONE_ON_RIGHT, 24'd1);
        queue_write(CFG_WIDE_SAMPLES, 24'd0);
        queue_write(CFG_SIGNED_SAMPLES, 24'd0);
        queue_request(1'b1);
        queue_request(1'b1);

        // A channel count of zero means one channel, so the tone is absent.
        queue_pause();
        queue_write(CFG_CHANNEL_TOTAL, 24'd0);
        queue_request(1'b1);
        queue_request(1'b1);

        // Count above the limit, big-endian offset words, quarter-turn steps
        // that land on every quadrant boundary and the sine peak.
        queue_pause();
        queue_write(CFG_CHANNEL_TOTAL, 24'd15);
        queue_write(CFG_TONE_ON_RIGHT, 24'd0);
        queue_write(CFG_WIDE_SAMPLES, 24'd1);
        queue_write(CFG_BIG_ENDIAN, 24'd1);
        queue_write(CFG_OUTPUT_RATE, 24'd8);
        queue_write(CFG_TONE_FREQUENCY, 24'd2);
        queue_write(CFG_FRAMES_PER_LOOP, 24'hFFFFFF);
        repeat (5) queue_request(1'b1);

        // Signed bytes, frequency far above the rate, a three-frame loop.
        queue_pause();
        queue_write(CFG_SIGNED_SAMPLES, 24'd1);
        queue_write(CFG_WIDE_SAMPLES, 24'd0);
        queue_write(CFG_TONE_FREQUENCY, 24'h3FFFF);
        queue_write(CFG_FRAMES_PER_LOOP, 24'd3);
        repeat (4) queue_request(1'b1);

        // Run the phase up on the largest rate, then lower the rate so the
        // stored phase lies beyond it; the loop length then drops to zero.
        queue_pause();
        queue_write(CFG_WIDE_SAMPLES, 24'd1);
        queue_write(CFG_OUTPUT_RATE, 24'h3FFFF);
        queue_write(CFG_TONE_FREQUENCY, 24'd262142);
        queue_write(CFG_FRAMES_PER_LOOP, 24'hFFFFFF);
        repeat (3) queue_request(1'b1);
        queue_pause();
        queue_write(CFG_OUTPUT_RATE, 24'd1000);
        queue_write(CFG_FRAMES_PER_LOOP, 24'd0);
        repeat (2) queue_request(1'b1);

        // Zero output rate holds the phase at zero.
        queue_pause();
        queue_write(CFG_OUTPUT_RATE, 24'd0);
        queue_write(CFG_FRAMES_PER_LOOP, 24'd5);
        queue_request(1'b1);
        queue_request(1'b0);
        queue_request(1'b1);

        // Random setups, each followed by a burst of requests.
        while (frames_queued < FRAME_TARGET) begin
            queue_pause();
            queue_random_setup(setups == 0);
            setups++;
            steady_source = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(10, 40)) queue_request($urandom_range(0, 9) != 0);
        end
        queue_pause();

        // Reset, then wait for the queue to run dry and the block to settle.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (stim_q.size() != 0 || req_valid) @(posedge clk);
        @(posedge clk);
        if (expected_samples.size() != 0)
            note_failure($sformatf("%0d samples never arrived", expected_samples.size()));

        $display("Run covered %0d frame requests and %0d empty ticks over %0d random setups",
                 frames_sent - idle_queued, idle_queued, setups);
        $display("%0d register writes, %0d samples compared, %0d mismatches",
                 writes_done, samples_seen, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
